FILE: sv/acfld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acfld_pkg
// Shared types and constants for the ASCII CAN frame line decoder.
// ----------------------------------------------------------------------------
package acfld_pkg;

	localparam int MAX_PAYLOAD_BYTES = 64;
	localparam int IDX_W             = $clog2(MAX_PAYLOAD_BYTES);
	// two payload banks, one per queued line
	localparam int ADDR_W            = IDX_W + 1;

	typedef struct packed {
		logic [7:0] character;
		logic       line_end;
	} char_req_t;

	typedef struct packed {
		logic        error;
		logic        extended_id;
		logic        remote;
		logic        flexible_rate;
		logic        bit_rate_switch;
		logic [31:0] identifier;
		logic [3:0]  length_code;
		logic [6:0]  payload_length;
		logic [5:0]  byte_index;
		logic [7:0]  data_byte;
		logic        last;
	} res_req_t;

	// one decoded line waiting to be emitted
	typedef struct packed {
		logic        error;
		logic        ext;
		logic        rtr;
		logic        fd;
		logic        brs;
		logic [31:0] identifier;
		logic [3:0]  dlc;
		logic [6:0]  len;
		logic        bank;
	} line_desc_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} pay_wr_t;

	typedef struct packed {
		logic nonempty;
		logic full;
	} queue_status_t;

endpackage

FILE: sv/acfld_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acfld_front
// Character parser: classifies each character by its position in the line,
// writes payload bytes and issues one line descriptor at end of line.
// ----------------------------------------------------------------------------
module acfld_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    take,
	input  acfld_pkg::char_req_t    req,
	output acfld_pkg::pay_wr_t      pay_wr,
	output logic                    push,
	output acfld_pkg::line_desc_t   desc
);

	localparam logic [3:0] KIND_EXT = 4'b0001;
	localparam logic [3:0] KIND_RTR = 4'b0010;
	localparam logic [3:0] KIND_FD  = 4'b0100;
	localparam logic [3:0] KIND_BRS = 4'b1000;

	function automatic logic [4:0] hex_dec(input logic [7:0] c);
		logic [4:0] r;
		r = 5'b0;
		if (c inside {["0":"9"]})      r = {1'b1, 4'(c - "0")};
		else if (c inside {["A":"F"]}) r = {1'b1, 4'(c - "A" + 8'd10)};
		else if (c inside {["a":"f"]}) r = {1'b1, 4'(c - "a" + 8'd10)};
		return r;
	endfunction

	function automatic logic [6:0] length_for(input logic [3:0] kind, input logic [3:0] dlc);
		logic [6:0] n;
		n = 7'd0;
		if (kind[1]) begin
			n = 7'd0;
		end else if (kind[2]) begin
			case (dlc)
				4'd9:    n = 7'd12;
				4'd10:   n = 7'd16;
				4'd11:   n = 7'd20;
				4'd12:   n = 7'd24;
				4'd13:   n = 7'd32;
				4'd14:   n = 7'd48;
				4'd15:   n = 7'd64;
				default: n = {3'b0, dlc};
			endcase
		end else begin
			n = (dlc > 4'd8) ? 7'd8 : {3'b0, dlc};
		end
		if (n > 7'(acfld_pkg::MAX_PAYLOAD_BYTES)) n = 7'(acfld_pkg::MAX_PAYLOAD_BYTES);
		return n;
	endfunction

	logic [7:0]  pos_q;
	logic [3:0]  kind_q;
	logic        kind_bad_q;
	logic [31:0] id_q;
	logic        hdr_bad_q;
	logic [3:0]  dlc_q;
	logic [6:0]  exp_q;
	logic [3:0]  hi_q;
	logic        data_bad_q;
	logic        bank_q;

	logic [3:0] id_digits;
	logic [4:0] hx;
	logic [7:0] k;
	logic       in_span;
	logic       is_char;
	logic       in_data;
	logic [8:0] need;
	logic       bad;

	assign id_digits = kind_q[0] ? 4'd8 : 4'd3;
	assign hx        = hex_dec(req.character);
	assign k         = pos_q - 8'(id_digits + 4'd2);
	assign in_span   = k < {exp_q, 1'b0};
	assign is_char   = take && !req.line_end;
	assign in_data   = pos_q > 8'(id_digits + 4'd1);

	assign pay_wr.en   = is_char && in_data && in_span && hx[4] && k[0];
	assign pay_wr.addr = {bank_q, k[acfld_pkg::IDX_W:1]};
	assign pay_wr.data = {hi_q, hx[3:0]};

	assign need = 9'(id_digits) + 9'd2 + {1'b0, exp_q, 1'b0};
	assign bad  = (pos_q == 8'd0) || kind_bad_q || hdr_bad_q || data_bad_q ||
	              ({1'b0, pos_q} < need);

	assign push = take && req.line_end;

	always_comb begin
		desc            = '0;
		desc.error      = bad;
		desc.bank       = bank_q;
		if (!bad) begin
			desc.ext        = kind_q[0];
			desc.rtr        = kind_q[1];
			desc.fd         = kind_q[2];
			desc.brs        = kind_q[3];
			desc.identifier = id_q;
			desc.dlc        = dlc_q;
			desc.len        = exp_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			kind_q     <= '0;
			kind_bad_q <= 1'b0;
			id_q       <= '0;
			hdr_bad_q  <= 1'b0;
			dlc_q      <= '0;
			exp_q      <= '0;
			hi_q       <= '0;
			data_bad_q <= 1'b0;
			bank_q     <= 1'b0;
		end else if (push) begin
			pos_q      <= '0;
			kind_q     <= '0;
			kind_bad_q <= 1'b0;
			id_q       <= '0;
			hdr_bad_q  <= 1'b0;
			dlc_q      <= '0;
			exp_q      <= '0;
			hi_q       <= '0;
			data_bad_q <= 1'b0;
			bank_q     <= !bank_q;
		end else if (is_char) begin
			if (pos_q == 8'd0) begin
				case (req.character)
					"t":     kind_q <= '0;
					"T":     kind_q <= KIND_EXT;
					"r":     kind_q <= KIND_RTR;
					"R":     kind_q <= KIND_EXT | KIND_RTR;
					"d":     kind_q <= KIND_FD;
					"D":     kind_q <= KIND_EXT | KIND_FD;
					"b":     kind_q <= KIND_FD | KIND_BRS;
					"B":     kind_q <= KIND_EXT | KIND_FD | KIND_BRS;
					default: begin
						kind_q     <= '0;
						kind_bad_q <= 1'b1;
					end
				endcase
			end else if (pos_q <= 8'(id_digits)) begin
				if (hx[4]) id_q <= {id_q[27:0], hx[3:0]};
				else       hdr_bad_q <= 1'b1;
			end else if (!in_data) begin
				if (hx[4]) begin
					dlc_q <= hx[3:0];
					exp_q <= length_for(kind_q, hx[3:0]);
				end else begin
					hdr_bad_q <= 1'b1;
				end
			end else if (in_span) begin
				if (!hx[4])     data_bad_q <= 1'b1;
				else if (!k[0]) hi_q <= hx[3:0];
			end
			if (pos_q != 8'hFF) pos_q <= pos_q + 8'd1;
		end
	end

endmodule

FILE: sv/acfld_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acfld_queue
// Two-entry descriptor queue between the parser and the result emitter.
// ----------------------------------------------------------------------------
module acfld_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  acfld_pkg::line_desc_t      push_desc,
	input  logic                       pop,
	output acfld_pkg::line_desc_t      head,
	output acfld_pkg::queue_status_t   status
);

	acfld_pkg::line_desc_t ent_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;

	assign head            = ent_q[rptr_q];
	assign status.nonempty = cnt_q != 2'd0;
	assign status.full     = cnt_q == 2'd2;

	always_ff @(posedge clk) begin
		if (push) ent_q[wptr_q] <= push_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= !wptr_q;
			if (pop)  rptr_q <= !rptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: sv/acfld_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acfld_back
// Result emitter: holds the banked payload memory, walks the head line one
// byte per cycle while res_stall is low and drives the result register.
// ----------------------------------------------------------------------------
module acfld_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  acfld_pkg::pay_wr_t      pay_wr,
	input  logic                    head_valid,
	input  acfld_pkg::line_desc_t   head,
	output logic                    pop,
	output logic                    res_valid,
	input  logic                    res_stall,
	output acfld_pkg::res_req_t     res_data
);

	logic [7:0] mem [2*acfld_pkg::MAX_PAYLOAD_BYTES];

	logic [6:0]            i_q;
	logic                  v_s1;
	acfld_pkg::line_desc_t desc_s1;
	logic [6:0]            idx_s1;
	logic                  last_s1;
	logic [7:0]            rd_s1;
	logic                  ov_q;
	acfld_pkg::res_req_t   out_q;

	logic out_adv;
	logic s1_adv;
	logic issue;
	logic is_last;

	assign out_adv = !ov_q || !res_stall;
	assign s1_adv  = v_s1 && out_adv;
	assign issue   = head_valid && (!v_s1 || s1_adv);
	assign is_last = (head.len == 7'd0) || ({1'b0, i_q} + 8'd1 >= {1'b0, head.len});
	assign pop     = issue && is_last;

	assign res_valid = ov_q;
	assign res_data  = out_q;

	always_ff @(posedge clk) begin
		if (pay_wr.en) mem[pay_wr.addr] <= pay_wr.data;
		if (issue) begin
			rd_s1   <= mem[{head.bank, i_q[acfld_pkg::IDX_W-1:0]}];
			desc_s1 <= head;
			idx_s1  <= i_q;
			last_s1 <= is_last;
		end
		if (s1_adv) begin
			out_q.error           <= desc_s1.error;
			out_q.extended_id     <= desc_s1.ext;
			out_q.remote          <= desc_s1.rtr;
			out_q.flexible_rate   <= desc_s1.fd;
			out_q.bit_rate_switch <= desc_s1.brs;
			out_q.identifier      <= desc_s1.identifier;
			out_q.length_code     <= desc_s1.dlc;
			out_q.payload_length  <= desc_s1.len;
			out_q.byte_index      <= idx_s1[5:0];
			out_q.data_byte       <= (desc_s1.len == 7'd0) ? 8'd0 : rd_s1;
			out_q.last            <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q  <= '0;
			v_s1 <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (issue) i_q <= is_last ? 7'd0 : i_q + 7'd1;
			if (issue)       v_s1 <= 1'b1;
			else if (s1_adv) v_s1 <= 1'b0;
			if (s1_adv)       ov_q <= 1'b1;
			else if (out_adv) ov_q <= 1'b0;
		end
	end

endmodule

FILE: sv/ascii_can_frame_line_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_can_frame_line_decoder_top
// Decodes text-format CAN / CAN FD lines into per-byte frame results.
// ----------------------------------------------------------------------------
// Input channel (char_*): one request per character, line_end = 1 closes the
// line. Output channel (res_*): one request per payload byte, a single one
// for an empty payload, or a single error request for a malformed line; the
// final request of a line has last = 1.
// Characters are taken one per cycle while char_stall is low. The first
// result of a line passes the line queue, the stage-one and the result
// registers; its results follow at one per cycle while res_stall is low.
// A two-entry line queue and two payload banks decouple parser and emitter:
// char_stall rises only while two decoded lines wait to be emitted, and
// drops the cycle after the emitter issues the last byte of the older one.
// res_stall holds the result register and backs up the emitter; the parser
// keeps taking characters until the queue fills.
// Reset clears the parser state, the queue and all valid flags; the payload
// memory is not cleared since a line only reads bytes it has written.
// ----------------------------------------------------------------------------
module ascii_can_frame_line_decoder_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  char_valid,
	output logic                  char_stall,
	input  acfld_pkg::char_req_t  char_data,
	output logic                  res_valid,
	input  logic                  res_stall,
	output acfld_pkg::res_req_t   res_data
);

	acfld_pkg::pay_wr_t       pay_wr;
	acfld_pkg::line_desc_t    new_desc;
	acfld_pkg::line_desc_t    head;
	acfld_pkg::queue_status_t q_st;
	logic take;
	logic push;
	logic pop;

	assign char_stall = q_st.full;
	assign take       = char_valid && !char_stall;

	acfld_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.req    (char_data),
		.pay_wr (pay_wr),
		.push   (push),
		.desc   (new_desc)
	);

	acfld_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (new_desc),
		.pop       (pop),
		.head      (head),
		.status    (q_st)
	);

	acfld_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pay_wr     (pay_wr),
		.head_valid (q_st.nonempty),
		.head       (head),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_data   (res_data)
	);

	// a line is never pushed into a full queue
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !q_st.full)
		else $error("line pushed into full queue");

	// parser must not overwrite the bank of the line being emitted
	assert property (@(posedge clk) disable iff (!arst_n)
		(pay_wr.en && q_st.nonempty) |-> (pay_wr.addr[acfld_pkg::ADDR_W-1] != head.bank))
		else $error("payload write hits bank in use");

	// pop only the line that is present
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> q_st.nonempty)
		else $error("pop from empty queue");

	// an error result is a lone, empty, final result
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_data.error) |-> (res_data.last && res_data.payload_length == 7'd0))
		else $error("malformed error result");

endmodule
